/* hw/rtl/lpht_pkg.sv */
package lpht_pkg;

  localparam int KEY_W     = 12;
  localparam int TAG_W     = 16;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int SLOT_W    = 6;
  localparam int CNT_W     = 7;
  localparam int TOTAL_W   = 12;
  localparam int DIV_CNT_W = 4;

  localparam int TABLE_DEPTH_DEF = 64;
  // table_size is 7 bits wide, so no probe ever reaches beyond this many slots
  localparam int MAX_SLOTS       = 127;

  localparam logic [CFG_W-1:0]     RESET_MODULUS  = 7'd51;
  localparam logic [CFG_W-1:0]     RESET_SIZE     = 7'd51;
  localparam logic [TOTAL_W-1:0]   TOTAL_MAX      = 12'hFFF;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_KEY  = 4'd12;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SIZE = 4'd7;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HASH_MODULUS = 2'd0,
    REG_TABLE_SIZE   = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STAT_INSERTED    = 2'd0,
    STAT_FOUND       = 2'd1,
    STAT_NOT_PRESENT = 2'd2,
    STAT_FULL        = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_KEY,
    S_SIZE_LOAD,
    S_DIV_SIZE,
    S_PROBE_LOAD,
    S_READ,
    S_CHECK,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic div_step;
    logic size_load;
    logic probe_load;
    logic read_slot;
    logic check;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic probe_end;
    logic out_free;
  } dp_stat_t;

endpackage

/* hw/rtl/lpht_if.sv */
interface lpht_cmd_if;
  import lpht_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [KEY_W-1:0]   key_sum;
  logic [TAG_W-1:0]   name_tag;

  modport source (output valid, action, key_sum, name_tag, input ready);
  modport sink (input valid, action, key_sum, name_tag, output ready);
endinterface

interface lpht_rsp_if;
  import lpht_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic [SLOT_W-1:0]  slot_index;
  logic [CNT_W-1:0]   probe_count;
  logic [TOTAL_W-1:0] total_probes;

  modport source (output valid, status, slot_index, probe_count, total_probes, input ready);
  modport sink (input valid, status, slot_index, probe_count, total_probes, output ready);
endinterface

interface lpht_cfg_if;
  import lpht_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/lpht_ctrl.sv */
module lpht_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output lpht_pkg::dp_cmd_t  cmd,
  input  lpht_pkg::dp_stat_t stat
);
  import lpht_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DIV_KEY;
        end
      end
      S_DIV_KEY: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_SIZE_LOAD;
        end
      end
      S_SIZE_LOAD: begin
        cmd.size_load = 1'b1;
        state_next    = S_DIV_SIZE;
      end
      S_DIV_SIZE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_PROBE_LOAD;
        end
      end
      S_PROBE_LOAD: begin
        cmd.probe_load = 1'b1;
        state_next     = S_READ;
      end
      S_READ: begin
        cmd.read_slot = 1'b1;
        state_next    = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = stat.probe_end ? S_RESULT : S_READ;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/lpht_dp.sv */
module lpht_dp #(
  parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lpht_pkg::dp_cmd_t              cmd,
  output lpht_pkg::dp_stat_t             stat,
  input  logic                           cfg_valid,
  input  logic [lpht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpht_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           item_action,
  input  logic [lpht_pkg::KEY_W-1:0]     item_key,
  input  logic [lpht_pkg::TAG_W-1:0]     item_tag,
  input  logic                           rsp_ready,
  output logic                           rsp_valid,
  output lpht_pkg::status_t              rsp_status,
  output logic [lpht_pkg::SLOT_W-1:0]    rsp_slot,
  output logic [lpht_pkg::CNT_W-1:0]     rsp_count,
  output logic [lpht_pkg::TOTAL_W-1:0]   rsp_total
);
  import lpht_pkg::*;

  localparam int SLOTS = (TABLE_DEPTH < MAX_SLOTS) ? TABLE_DEPTH : MAX_SLOTS;
  localparam int IW    = $clog2(SLOTS);
  localparam int CW    = ((IW > CNT_W) ? IW : CNT_W) + 1;

  // configuration
  logic [CFG_W-1:0] hash_modulus;
  logic [CFG_W-1:0] table_size;
  logic [CFG_W-1:0] mod_eff;
  logic [CFG_W-1:0] size_nz;
  logic [CFG_W-1:0] size_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_modulus <= RESET_MODULUS;
      table_size   <= RESET_SIZE;
    end else if (cfg_valid) begin
      if (cfg_index == REG_HASH_MODULUS) begin
        hash_modulus <= cfg_data;
      end
      if (cfg_index == REG_TABLE_SIZE) begin
        table_size <= cfg_data;
      end
    end
  end

  assign mod_eff  = (hash_modulus == '0) ? CFG_W'(1) : hash_modulus;
  assign size_nz  = (table_size == '0) ? CFG_W'(1) : table_size;
  assign size_eff = (CW'(size_nz) > CW'(SLOTS)) ? CFG_W'(SLOTS) : size_nz;

  // item capture
  logic             act_q;
  logic [TAG_W-1:0] tag_q;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_q <= item_action;
      tag_q <= item_tag;
    end
  end

  // bit-serial remainder unit
  logic [CFG_W-1:0]     rem;
  logic [KEY_W-1:0]     dvd;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CFG_W-1:0]     divisor;
  logic [CFG_W:0]       trial;
  logic                 trial_ge;
  logic [CFG_W-1:0]     rem_step;

  assign trial    = {rem, dvd[KEY_W-1]};
  assign trial_ge = trial >= {1'b0, divisor};
  assign rem_step = trial_ge ? CFG_W'(trial - {1'b0, divisor}) : CFG_W'(trial);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      rem     <= '0;
      dvd     <= item_key;
      div_cnt <= DIV_STEPS_KEY;
      divisor <= mod_eff;
    end else if (cmd.size_load) begin
      rem     <= '0;
      dvd     <= {rem, (KEY_W - CFG_W)'(0)};
      div_cnt <= DIV_STEPS_SIZE;
      divisor <= size_eff;
    end else if (cmd.div_step) begin
      rem     <= rem_step;
      dvd     <= {dvd[KEY_W-2:0], 1'b0};
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  // slot storage
  logic [SLOTS-1:0] used;
  logic [TAG_W-1:0] tag_mem [SLOTS];
  logic             used_rd;
  logic [TAG_W-1:0] tag_rd;

  // probe walk
  logic [IW-1:0]    pos;
  logic [CNT_W-1:0] n;
  logic [CW-1:0]    pos_inc;
  logic             slot_free;
  logic             tag_match;
  logic             last_probe;
  logic             probe_end;
  logic             do_insert;
  logic [TOTAL_W:0] total_sum;
  logic [TOTAL_W-1:0] total;

  assign pos_inc    = CW'(pos) + CW'(1);
  assign slot_free  = !used_rd;
  assign tag_match  = (act_q == ACT_SEARCH) && (tag_rd == tag_q);
  assign last_probe = (n == size_eff);
  assign probe_end  = slot_free || tag_match || last_probe;
  assign do_insert  = cmd.check && slot_free && (act_q == ACT_INSERT);
  assign total_sum  = {1'b0, total} + (TOTAL_W + 1)'(n);

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (do_insert) begin
      used[pos] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      tag_mem[pos] <= tag_q;
    end
    if (cmd.read_slot) begin
      tag_rd  <= tag_mem[pos];
      used_rd <= used[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_load) begin
      pos <= IW'(rem);
      n   <= CNT_W'(1);
    end else if (cmd.check && !probe_end) begin
      pos <= (pos_inc >= CW'(size_eff)) ? '0 : IW'(pos_inc);
      n   <= n + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (do_insert) begin
      total <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    end
  end

  // result of the finished probe walk
  status_t          res_status;
  logic [IW-1:0]    res_slot;
  logic [CNT_W-1:0] res_count;
  logic [CW-1:0]    res_slot_ext;

  always_ff @(posedge clk) begin
    if (cmd.check && probe_end) begin
      res_count <= n;
      if (slot_free) begin
        res_status <= (act_q == ACT_INSERT) ? STAT_INSERTED : STAT_NOT_PRESENT;
        res_slot   <= (act_q == ACT_INSERT) ? pos : '0;
      end else if (tag_match) begin
        res_status <= STAT_FOUND;
        res_slot   <= pos;
      end else begin
        res_status <= (act_q == ACT_INSERT) ? STAT_FULL : STAT_NOT_PRESENT;
        res_slot   <= '0;
      end
    end
  end

  assign res_slot_ext = CW'(res_slot);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.push) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rsp_status <= res_status;
      rsp_slot   <= res_slot_ext[SLOT_W-1:0];
      rsp_count  <= res_count;
      rsp_total  <= total;
    end
  end

  assign stat.div_last  = (div_cnt == DIV_CNT_W'(1));
  assign stat.probe_end = probe_end;
  assign stat.out_free  = !rsp_valid || rsp_ready;

endmodule

/* hw/rtl/linear_probe_hash_table_core.sv */
// one command at a time: a new command is taken only after the response is pushed
// the home slot comes from a bit-serial remainder unit (12 steps by modulus, 7 by size)
// each probe reads the tag memory into a register (S_READ), then checks the slot (S_CHECK)
// rst (synchronous) clears the used marks and the running total, sets both registers to 51
module linear_probe_hash_table_core #(
  parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  lpht_cmd_if.sink  cmd,
  lpht_rsp_if.source rsp,
  lpht_cfg_if.sink  cfg
);
  import lpht_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     in_ready;

  assign cmd.ready = in_ready;
  assign cfg.ready = 1'b1;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (in_ready),
    .cmd      (dp_cmd),
    .stat     (dp_stat)
  );

  lpht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dp_cmd),
    .stat        (dp_stat),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .item_action (cmd.action),
    .item_key    (cmd.key_sum),
    .item_tag    (cmd.name_tag),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp.valid),
    .rsp_status  (rsp.status),
    .rsp_slot    (rsp.slot_index),
    .rsp_count   (rsp.probe_count),
    .rsp_total   (rsp.total_probes)
  );

endmodule
